// ===== hw/rtl/axis_angle_rotation_matrix_defines.svh =====
// Assertion macros used by axis_angle_rotation_matrix.sv.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH

`ifndef ASSERT_OFF
`define AARM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define AARM_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AARM_ASSERT(lbl, prop, msg)
`define AARM_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/aarm_pkg.sv =====
package aarm_pkg;

  localparam logic [31:0] DEG_FULL    = 32'd23592960;
  localparam logic [31:0] MOD_BIAS    = 32'd524288;
  localparam logic signed [26:0] F27  = 27'sd23592960;
  localparam logic signed [26:0] H27  = 27'sd11796480;
  localparam logic signed [26:0] Q27  = 27'sd5898240;
  localparam logic signed [27:0] RAD_PER_DEG = 28'sd74961321;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [31:0] ONE32       = 32'sd1073741824;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] a;
    unique case (idx)
      5'd0:  a = 34'h0_3243_F6A8;
      5'd1:  a = 34'h0_1DAC_6705;
      5'd2:  a = 34'h0_0FAD_BAFC;
      5'd3:  a = 34'h0_07F5_6EA6;
      5'd4:  a = 34'h0_03FE_AB76;
      5'd5:  a = 34'h0_01FF_D55B;
      5'd6:  a = 34'h0_00FF_FAAA;
      5'd7:  a = 34'h0_007F_FF55;
      5'd8:  a = 34'h0_003F_FFEA;
      5'd9:  a = 34'h0_001F_FFFD;
      5'd10: a = 34'h0_000F_FFFF;
      5'd11: a = 34'h0_0007_FFFF;
      5'd12: a = 34'h0_0003_FFFF;
      5'd13: a = 34'h0_0001_FFFF;
      5'd14: a = 34'h0_0000_FFFF;
      5'd15: a = 34'h0_0000_7FFF;
      5'd16: a = 34'h0_0000_3FFF;
      5'd17: a = 34'h0_0000_1FFF;
      5'd18: a = 34'h0_0000_0FFF;
      5'd19: a = 34'h0_0000_07FF;
      5'd20: a = 34'h0_0000_03FF;
      5'd21: a = 34'h0_0000_01FF;
      5'd22: a = 34'h0_0000_00FF;
      5'd23: a = 34'h0_0000_007F;
      5'd24: a = 34'h0_0000_003F;
      5'd25: a = 34'h0_0000_001F;
      5'd26: a = 34'h0_0000_000F;
      5'd27: a = 34'h0_0000_0008;
      5'd28: a = 34'h0_0000_0004;
      5'd29: a = 34'h0_0000_0002;
      5'd30: a = 34'h0_0000_0001;
      default: a = 34'h0_0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/axis_angle_rotation_matrix.sv =====
// Rotation matrix from angle and axis (Rodrigues form).
// Slave stream: one transfer carries angle_deg and axis x, y, z, all signed Q16.16.
// Master stream: one transfer per input carries the nine entries m00..m22 in
// signed Q2.30, row-major, and tuser carries zero_axis (axis all zero, matrix is
// then the identity).
// Timing: the delay from the input transfer to tvalid on the output does not depend on
// CORDIC_STAGES; the 32-step square root and the 32-step divide of the axis path
// set it, the angle path (mod, fold, CORDIC) is delayed to meet them.
// Throughput: one transfer per cycle in and out while the output is not stalled, every stage registered.
// Stall: when the output holds a result that is not taken, the whole pipeline
// holds and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset: asynchronous, clears all valid bits; the output is empty after reset.
`include "axis_angle_rotation_matrix_defines.svh"

module axis_angle_rotation_matrix
  import aarm_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // angle_deg, axis_x, axis_y, axis_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [0:0]   m_axis_tuser    // zero_axis
);

  localparam int unsigned AXIS_LAT = 71;
  localparam int unsigned ANG_LAT  = 8 + CORDIC_STAGES;
  localparam int unsigned DLY      = AXIS_LAT - ANG_LAT;
  localparam int unsigned SQ_END   = 37;
  localparam int unsigned LAST     = AXIS_LAT + 4;

  logic            adv;
  logic [LAST:0]   vld_q;

  assign adv           = !vld_q[LAST] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:0], s_axis_tvalid};
    end
  end

  // input register
  logic signed [31:0] deg_q;
  logic signed [31:0] vin_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      deg_q    <= s_axis_tdata[31:0];
      vin_q[0] <= s_axis_tdata[63:32];
      vin_q[1] <= s_axis_tdata[95:64];
      vin_q[2] <= s_axis_tdata[127:96];
    end
  end

  // ---------------- angle path ----------------
  logic [31:0] mrem_in [4];
  logic [31:0] mrem_q  [4];

  assign mrem_in[0] = {~deg_q[31], deg_q[30:0]};

  for (genvar g = 0; g < 4; g++) begin : g_mod
    localparam logic [31:0] DHI = DEG_FULL << (7 - 2 * g);
    localparam logic [31:0] DLO = DEG_FULL << (6 - 2 * g);
    logic [31:0] r1, r2;
    if (g > 0) begin : g_src
      assign mrem_in[g] = mrem_q[g-1];
    end
    always_comb begin
      r1 = (mrem_in[g] >= DHI) ? mrem_in[g] - DHI : mrem_in[g];
      r2 = (r1 >= DLO) ? r1 - DLO : r1;
    end
    always_ff @(posedge clk_i) begin
      if (adv) mrem_q[g] <= r2;
    end
  end

  logic signed [26:0] fr0, fr1, fr2, fold_d, fold_q;
  logic               fneg_d;
  logic               nq_q [CORDIC_STAGES+3];

  always_comb begin
    fr0    = $signed({2'b00, mrem_q[3][24:0]}) - $signed(27'(MOD_BIAS));
    fr1    = (fr0 < 0) ? fr0 + F27 : fr0;
    fr2    = (fr1 > H27) ? fr1 - F27 : fr1;
    fneg_d = 1'b0;
    fold_d = fr2;
    if (fr2 > Q27) begin
      fold_d = fr2 - H27;
      fneg_d = 1'b1;
    end else if (fr2 < -Q27) begin
      fold_d = fr2 + H27;
      fneg_d = 1'b1;
    end
  end

  logic signed [54:0] rprod_q;
  logic signed [54:0] zr;
  logic signed [33:0] z0_q;

  assign zr = (rprod_q + 55'sd131072) >>> 18;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fold_q  <= fold_d;
      rprod_q <= 55'(fold_q) * 55'(RAD_PER_DEG);
      z0_q    <= zr[33:0];
      nq_q[0] <= fneg_d;
      for (int k = 1; k < CORDIC_STAGES + 3; k++) nq_q[k] <= nq_q[k-1];
    end
  end

  logic signed [33:0] cx_q [CORDIC_STAGES];
  logic signed [33:0] cy_q [CORDIC_STAGES];
  logic signed [33:0] cz_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [33:0] xi, yi, zi, dx, dy;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z0_q;
    end else begin : g_next
      assign xi = cx_q[i-1];
      assign yi = cy_q[i-1];
      assign zi = cz_q[i-1];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!zi[33]) begin
          cx_q[i] <= xi - dx;
          cy_q[i] <= yi + dy;
          cz_q[i] <= zi - atan_q30(5'(i));
        end else begin
          cx_q[i] <= xi + dx;
          cy_q[i] <= yi - dy;
          cz_q[i] <= zi + atan_q30(5'(i));
        end
      end
    end
  end

  logic signed [33:0] xcl, ycl;
  logic signed [31:0] cos_q, sin_q;
  logic signed [31:0] cdl_q [DLY];
  logic signed [31:0] sdl_q [DLY];

  always_comb begin
    xcl = cx_q[CORDIC_STAGES-1];
    ycl = cy_q[CORDIC_STAGES-1];
    if (xcl > Q30_ONE) xcl = Q30_ONE;
    else if (xcl < -Q30_ONE) xcl = -Q30_ONE;
    if (ycl > Q30_ONE) ycl = Q30_ONE;
    else if (ycl < -Q30_ONE) ycl = -Q30_ONE;
    if (nq_q[CORDIC_STAGES+2]) begin
      xcl = -xcl;
      ycl = -ycl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos_q    <= xcl[31:0];
      sin_q    <= ycl[31:0];
      cdl_q[0] <= cos_q;
      sdl_q[0] <= sin_q;
      for (int k = 1; k < DLY; k++) begin
        cdl_q[k] <= cdl_q[k-1];
        sdl_q[k] <= sdl_q[k-1];
      end
    end
  end

  // ---------------- axis path ----------------
  logic [3:0]  side_q [AXIS_LAT];
  logic [31:0] nm_q   [3][3];
  logic [31:0] nb_q   [3];
  logic [31:0] m0 [3], m1 [3], m2 [3];
  logic [31:0] b0, b1, b2, b1a, b2a;
  logic [2:0]  sgn_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m0[i]    = vin_q[i][31] ? 32'(-vin_q[i]) : vin_q[i];
      sgn_d[i] = vin_q[i][31];
    end
    b0 = m0[0];
    if (m0[1] > b0) b0 = m0[1];
    if (m0[2] > b0) b0 = m0[2];
    if (b0[31:15] == '0) begin
      b0 = b0 << 16;
      for (int i = 0; i < 3; i++) m0[i] = m0[i] << 16;
    end
    b1a = nb_q[0];
    for (int i = 0; i < 3; i++) m1[i] = nm_q[0][i];
    if (b1a[31:23] == '0) begin
      b1a = b1a << 8;
      for (int i = 0; i < 3; i++) m1[i] = m1[i] << 8;
    end
    b1 = b1a;
    if (b1[31:27] == '0) begin
      b1 = b1 << 4;
      for (int i = 0; i < 3; i++) m1[i] = m1[i] << 4;
    end
    b2a = nb_q[1];
    for (int i = 0; i < 3; i++) m2[i] = nm_q[1][i];
    if (b2a[31:29] == '0) begin
      b2a = b2a << 2;
      for (int i = 0; i < 3; i++) m2[i] = m2[i] << 2;
    end
    b2 = b2a;
    if (b2[31:30] == '0) begin
      b2 = b2 << 1;
      for (int i = 0; i < 3; i++) m2[i] = m2[i] << 1;
    end
  end

  logic [63:0] sq_q [3];
  logic [63:0] sum_q;
  logic [31:0] mcar_q [34][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= {vin_q[0] == '0 && vin_q[1] == '0 && vin_q[2] == '0, sgn_d};
      for (int k = 1; k < AXIS_LAT; k++) side_q[k] <= side_q[k-1];
      nm_q[0] <= m0;
      nb_q[0] <= b0;
      nm_q[1] <= m1;
      nb_q[1] <= b1;
      nm_q[2] <= m2;
      nb_q[2] <= b2;
      for (int i = 0; i < 3; i++) sq_q[i] <= 64'(nm_q[2][i]) * 64'(nm_q[2][i]);
      sum_q     <= sq_q[0] + sq_q[1] + sq_q[2];
      mcar_q[0] <= nm_q[2];
      for (int k = 1; k < 34; k++) mcar_q[k] <= mcar_q[k-1];
    end
  end

  logic [63:0] sv_q [32];
  logic [63:0] sr_q [32];

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] v_in, r_in, trial;
    if (k == 0) begin : g_first
      assign v_in = sum_q;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = sv_q[k-1];
      assign r_in = sr_q[k-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (v_in >= trial) begin
          sv_q[k] <= v_in - trial;
          sr_q[k] <= (r_in >> 1) + BIT;
        end else begin
          sv_q[k] <= v_in;
          sr_q[k] <= r_in >> 1;
        end
      end
    end
  end

  logic [31:0] root;
  logic [61:0] numr [3];
  logic [31:0] pr_rem_q [3];
  logic [31:0] pr_dq_q  [3];
  logic [31:0] pr_dv_q;

  assign root = sr_q[31][31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numr[i] = {mcar_q[33][i], 30'd0} + 62'(root >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pr_rem_q[i] <= {2'b00, numr[i][61:32]};
        pr_dq_q[i]  <= numr[i][31:0];
      end
      pr_dv_q <= root;
    end
  end

  logic [31:0] rem_q [32][3];
  logic [31:0] dq_q  [32][3];
  logic [31:0] dv_q  [32];

  for (genvar d = 0; d < 32; d++) begin : g_div
    logic [31:0] rin [3];
    logic [31:0] qin [3];
    logic [31:0] vin;
    logic [32:0] sh  [3];
    if (d == 0) begin : g_first
      assign rin = pr_rem_q;
      assign qin = pr_dq_q;
      assign vin = pr_dv_q;
    end else begin : g_next
      assign rin = rem_q[d-1];
      assign qin = dq_q[d-1];
      assign vin = dv_q[d-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[d] <= vin;
        for (int i = 0; i < 3; i++) begin
          if (sh[i] >= {1'b0, vin}) begin
            rem_q[d][i] <= 32'(sh[i] - {1'b0, vin});
            dq_q[d][i]  <= {qin[i][30:0], 1'b1};
          end else begin
            rem_q[d][i] <= sh[i][31:0];
            dq_q[d][i]  <= {qin[i][30:0], 1'b0};
          end
        end
      end
    end
    always_comb begin
      for (int i = 0; i < 3; i++) sh[i] = {rin[i], qin[i][31]};
    end
  end

  logic signed [32:0] u_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= side_q[AXIS_LAT-2][i] ? -$signed({1'b0, dq_q[31][i]})
                                         : $signed({1'b0, dq_q[31][i]});
      end
    end
  end

  // ---------------- matrix assembly ----------------
  logic signed [32:0] cdel, sdel;
  logic               zdel;
  logic               zp_q [4];

  assign cdel = {cdl_q[DLY-1][31], cdl_q[DLY-1]};
  assign sdel = {sdl_q[DLY-1][31], sdl_q[DLY-1]};
  assign zdel = side_q[AXIS_LAT-1][3];

  logic signed [65:0] uup_q [6];
  logic signed [65:0] sup_q [3];
  logic signed [31:0] c1_q, c2_q, c3_q;
  logic signed [32:0] omc1_q, omc2_q;
  logic signed [33:0] uur_q [6];
  logic signed [33:0] srp_q [3];
  logic signed [33:0] srn_q [3];
  logic signed [33:0] srp3_q [3];
  logic signed [33:0] srn3_q [3];
  logic signed [66:0] t_q [6];

  for (genvar p = 0; p < 6; p++) begin : g_uu
    localparam int A = (p < 3) ? 0 : ((p < 5) ? 1 : 2);
    localparam int B = (p < 3) ? p : ((p < 5) ? p - 2 : 2);
    logic signed [65:0] rsum;
    assign rsum = (uup_q[p] + 66'sd536870912) >>> 30;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        uup_q[p] <= u_q[A] * u_q[B];
        uur_q[p] <= rsum[33:0];
        t_q[p]   <= 67'(omc2_q) * 67'(uur_q[p]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_su
    logic signed [65:0] rp, rn;
    assign rp = (sup_q[k] + 66'sd536870912) >>> 30;
    assign rn = (66'sd536870912 - sup_q[k]) >>> 30;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sup_q[k]  <= sdel * u_q[k];
        srp_q[k]  <= rp[33:0];
        srn_q[k]  <= rn[33:0];
        srp3_q[k] <= srp_q[k];
        srn3_q[k] <= srn_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q   <= cdel[31:0];
      omc1_q <= 33'sd1073741824 - cdel;
      c2_q   <= c1_q;
      omc2_q <= omc1_q;
      c3_q   <= c2_q;
      zp_q[0] <= zdel;
      for (int k = 1; k < 4; k++) zp_q[k] <= zp_q[k-1];
    end
  end

  logic signed [31:0] mo_q [9];

  for (genvar e = 0; e < 9; e++) begin : g_entry
    localparam int R    = e / 3;
    localparam int C    = e % 3;
    localparam int LO   = (R < C) ? R : C;
    localparam int HI   = (R < C) ? C : R;
    localparam int UI   = (LO == 0) ? HI : ((LO == 1) ? HI + 2 : 5);
    localparam int K    = (e == 1 || e == 3) ? 2 : ((e == 2 || e == 6) ? 1 : 0);
    localparam bit NEG  = (e == 1 || e == 5 || e == 6);
    localparam bit DIAG = (R == C);
    logic signed [66:0] tr;
    logic signed [38:0] acc;
    logic signed [31:0] res;
    always_comb begin
      tr  = (t_q[UI] + 67'sd536870912) >>> 30;
      acc = tr[38:0];
      if (DIAG) acc = acc + 39'(c3_q);
      else if (NEG) acc = acc + 39'(srn3_q[K]);
      else acc = acc + 39'(srp3_q[K]);
      if (acc > 39'sd2147483647) res = 32'sh7FFF_FFFF;
      else if (acc < -39'sd2147483648) res = 32'sh8000_0000;
      else res = acc[31:0];
      if (zp_q[2]) res = DIAG ? ONE32 : '0;
    end
    always_ff @(posedge clk_i) begin
      if (adv) mo_q[e] <= res;
    end
  end

  assign m_axis_tdata = {mo_q[8], mo_q[7], mo_q[6], mo_q[5], mo_q[4],
                         mo_q[3], mo_q[2], mo_q[1], mo_q[0]};
  assign m_axis_tuser = zp_q[3];

  `AARM_ASSERT_NR(a_rst_empty, !rst_ni |=> !m_axis_tvalid, "output valid after reset")
  `AARM_ASSERT(a_zero_ident, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == ONE32 && m_axis_tdata[63:32] == '0 && m_axis_tdata[159:128] == ONE32, "zero axis not identity")
  `AARM_ASSERT(a_diag_floor, m_axis_tvalid |-> $signed(m_axis_tdata[31:0]) >= -ONE32 && $signed(m_axis_tdata[159:128]) >= -ONE32 && $signed(m_axis_tdata[287:256]) >= -ONE32, "diagonal below -1")
  `AARM_ASSERT(a_cs_range, vld_q[ANG_LAT] |-> cos_q >= -ONE32 && cos_q <= ONE32 && sin_q >= -ONE32 && sin_q <= ONE32, "cos or sin out of range")
  `AARM_ASSERT(a_root_norm, vld_q[SQ_END] && !side_q[SQ_END-1][3] |-> sr_q[31] >= 64'd1073741824, "root of normalized axis too small")

endmodule
